// ===== rtl/core/assert_macros.svh =====
// shared assertion macros, clocked on the rising edge and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every edge
`define CHECK_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/wbps_pkg.sv =====
package wbps_pkg;

   // field widths fixed by the block's interface
   localparam int DATA_WIDTH        = 8;
   localparam int ADDR_WIDTH        = 64;
   localparam int MATCH_TOTAL_WIDTH = 32;
   localparam int LEN_WIDTH         = 6;
   localparam int MASK_WIDTH        = 32;
   localparam int PATTERN_WORDS     = 4;
   localparam int WORD_WIDTH        = 64;
   localparam int CSR_INDEX_WIDTH   = 4;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_0  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_1  = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_2  = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_3  = 4'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CARE_MASK  = 4'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LENGTH     = 4'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FIND_ALL   = 4'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BASE       = 4'd7;

   // result kinds
   localparam logic KIND_MATCH      = 1'b0;
   localparam logic KIND_COMPLETION = 1'b1;

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = 2;
   localparam int QCNT_WIDTH  = 3;

   // pattern bytes, byte k in element k
   typedef logic [PATTERN_WORDS*WORD_WIDTH/DATA_WIDTH-1:0][DATA_WIDTH-1:0] pattern_bytes_type;

   // one result item
   typedef struct packed {
      logic                         kind;
      logic [ADDR_WIDTH-1:0]        match_address;
      logic                         found_any;
      logic [MATCH_TOTAL_WIDTH-1:0] match_total;
      logic                         last_of_run;
   } rsp_item_type;

   // queue write control from the scanner
   typedef struct packed {
      logic push_first;
      logic push_second;
   } q_push_type;

   // queue status back to the scanner
   typedef struct packed {
      logic not_empty;
      logic has_room;
   } q_status_type;

endpackage

// ===== rtl/core/wbps_ifs.sv =====
// byte input channel
interface wbps_req_if import wbps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] data_byte;
   logic                  end_of_region;

   modport source (output valid, output data_byte, output end_of_region, input ready);
   modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

// result channel
interface wbps_rsp_if import wbps_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [ADDR_WIDTH-1:0]        match_address;
   logic                         found_any;
   logic [MATCH_TOTAL_WIDTH-1:0] match_total;
   logic                         last_of_run;

   modport source (output valid, output kind, output match_address, output found_any,
                   output match_total, output last_of_run, input ready);
   modport sink   (input valid, input kind, input match_address, input found_any,
                   input match_total, input last_of_run, output ready);
endinterface

// configuration write channel
interface wbps_csr_if import wbps_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [WORD_WIDTH-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/wildcard_byte_pattern_scanner.sv =====
// channel   direction  payload
// req_chan  in         data_byte, end_of_region
// rsp_chan  out        kind, match_address, found_any, match_total, last_of_run
// csr_chan  in         index, data (register write, always ready)
//
// one byte is taken per cycle; the masked window compare, counters and result
// formatting all settle in the accept cycle and land in a four-entry result queue
// the first result is offered in the cycle after the accept if the queue was empty
// an item causes zero, one or two results; req_chan.ready drops while the queue has
// fewer than two free entries, so a stalled rsp_chan holds back the input
// reset is synchronous and clears the window, counters, configuration and queue
`include "assert_macros.svh"

module wildcard_byte_pattern_scanner import wbps_pkg::*; #(
   parameter int PATTERN_MAX = 32,
   parameter int COUNT_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   wbps_req_if.sink  req_chan,
   wbps_rsp_if.source rsp_chan,
   wbps_csr_if.sink  csr_chan
);

   localparam int HIT_WIDTH = (COUNT_WIDTH >= MATCH_TOTAL_WIDTH) ? MATCH_TOTAL_WIDTH : COUNT_WIDTH;

   // configuration
   logic [PATTERN_WORDS-1:0][WORD_WIDTH-1:0] pattern_ff;
   logic [MASK_WIDTH-1:0]                    care_mask_ff;
   logic [LEN_WIDTH-1:0]                     pattern_length_ff;
   logic                                     find_all_ff;
   logic [ADDR_WIDTH-1:0]                    region_base_ff;

   // region state
   logic [PATTERN_MAX-1:0][DATA_WIDTH-1:0] window_ff, window_in;
   logic [COUNT_WIDTH-1:0]                 seen_ff, seen_in;
   logic [HIT_WIDTH-1:0]                   hits_ff, hits_in;
   logic                                   stopped_ff, stopped_in;

   logic                        req_accept;
   logic [LEN_WIDTH-1:0]        len_eff;
   logic [COUNT_WIDTH-1:0]      seen_next;
   logic [COUNT_WIDTH-1:0]      offset;
   logic                        window_hit;
   logic                        hit;
   logic [HIT_WIDTH-1:0]        hits_next;
   rsp_item_type                match_item;
   rsp_item_type                done_item;
   rsp_item_type                item_first;
   rsp_item_type                head;
   q_push_type                  q_push;
   q_status_type                q_status;

   // configuration writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff        <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= '0;
         find_all_ff       <= 1'b0;
         region_base_ff    <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_PATTERN_0: pattern_ff[0] <= csr_chan.data;
            REG_PATTERN_1: pattern_ff[1] <= csr_chan.data;
            REG_PATTERN_2: pattern_ff[2] <= csr_chan.data;
            REG_PATTERN_3: pattern_ff[3] <= csr_chan.data;
            REG_CARE_MASK: care_mask_ff <= csr_chan.data[MASK_WIDTH-1:0];
            REG_LENGTH:    pattern_length_ff <= csr_chan.data[LEN_WIDTH-1:0];
            REG_FIND_ALL:  find_all_ff <= csr_chan.data[0];
            REG_BASE:      region_base_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // window shift and byte count
   assign req_accept = req_chan.valid && req_chan.ready;
   assign len_eff    = (pattern_length_ff > LEN_WIDTH'(PATTERN_MAX)) ?
                       LEN_WIDTH'(PATTERN_MAX) : pattern_length_ff;
   assign seen_next  = (seen_ff == '1) ? seen_ff : seen_ff + COUNT_WIDTH'(1);

   always_comb begin
      for (int i = PATTERN_MAX - 1; i > 0; i--) begin
         window_in[i] = window_ff[i-1];
      end
      window_in[0] = req_chan.data_byte;
   end

   wbps_matcher #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_matcher (
      .window     (window_in),
      .pattern    (pattern_bytes_type'(pattern_ff)),
      .care_mask  (care_mask_ff),
      .len        (len_eff),
      .window_hit (window_hit)
   );

   // match decision and counters
   assign hit       = (len_eff != '0) && !stopped_ff &&
                      (seen_next >= COUNT_WIDTH'(len_eff)) && window_hit;
   assign hits_next = (hit && (hits_ff != '1)) ? hits_ff + HIT_WIDTH'(1) : hits_ff;
   assign offset    = seen_next - COUNT_WIDTH'(len_eff);

   // result items
   always_comb begin
      match_item.kind          = KIND_MATCH;
      match_item.match_address = region_base_ff + ADDR_WIDTH'(offset);
      match_item.found_any     = (hits_next != '0);
      match_item.match_total   = MATCH_TOTAL_WIDTH'(hits_next);
      match_item.last_of_run   = !req_chan.end_of_region;

      done_item.kind           = KIND_COMPLETION;
      done_item.match_address  = '0;
      done_item.found_any      = (hits_next != '0);
      done_item.match_total    = MATCH_TOTAL_WIDTH'(hits_next);
      done_item.last_of_run    = 1'b1;

      item_first               = hit ? match_item : done_item;
      q_push.push_first        = req_accept && (hit || req_chan.end_of_region);
      q_push.push_second       = req_accept && hit && req_chan.end_of_region;
   end

   // region state update, cleared after the final byte
   always_comb begin
      if (req_chan.end_of_region) begin
         seen_in    = '0;
         hits_in    = '0;
         stopped_in = 1'b0;
      end else begin
         seen_in    = seen_next;
         hits_in    = hits_next;
         stopped_in = stopped_ff || (hit && !find_all_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         seen_ff    <= '0;
         hits_ff    <= '0;
         stopped_ff <= 1'b0;
      end else if (req_accept) begin
         window_ff  <= req_chan.end_of_region ? '0 : window_in;
         seen_ff    <= seen_in;
         hits_ff    <= hits_in;
         stopped_ff <= stopped_in;
      end
   end

   // result queue
   wbps_result_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (q_push),
      .item_first  (item_first),
      .item_second (done_item),
      .pop_ready   (rsp_chan.ready),
      .head        (head),
      .status      (q_status)
   );

   assign req_chan.ready         = q_status.has_room;
   assign rsp_chan.valid         = q_status.not_empty;
   assign rsp_chan.kind          = head.kind;
   assign rsp_chan.match_address = head.match_address;
   assign rsp_chan.found_any     = head.found_any;
   assign rsp_chan.match_total   = head.match_total;
   assign rsp_chan.last_of_run   = head.last_of_run;

   `CHECK_NEXT(a_region_clears, clock, reset, req_accept && req_chan.end_of_region, seen_ff == '0 && hits_ff == '0 && !stopped_ff, "region state not cleared")
   `CHECK_NEXT(a_first_only_stops, clock, reset, req_accept && hit && !find_all_ff && !req_chan.end_of_region, stopped_ff, "reporting not stopped")
   `CHECK_ALWAYS(a_stopped_has_hit, clock, reset, !stopped_ff || (hits_ff != '0), "stopped with no match")

endmodule

// ===== rtl/core/wbps_matcher.sv =====
module wbps_matcher import wbps_pkg::*; #(
   parameter int PATTERN_MAX = 32
) (
   input  logic [PATTERN_MAX-1:0][DATA_WIDTH-1:0] window,
   input  pattern_bytes_type                      pattern,
   input  logic [MASK_WIDTH-1:0]                  care_mask,
   input  logic [LEN_WIDTH-1:0]                   len,
   output logic                                   window_hit
);

   localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   // pattern byte k lines up with the byte that arrived len-1-k items ago
   always_comb begin
      logic [LEN_WIDTH-1:0] age;
      window_hit = 1'b1;
      age        = '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         age = len - LEN_WIDTH'(k) - LEN_WIDTH'(1);
         if ((LEN_WIDTH'(k) < len) && care_mask[k] &&
             (window[age[AW-1:0]] != pattern[k])) begin
            window_hit = 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/wbps_result_queue.sv =====
`include "assert_macros.svh"

module wbps_result_queue import wbps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_push_type   push,
   input  rsp_item_type item_first,
   input  rsp_item_type item_second,
   input  logic         pop_ready,
   output rsp_item_type head,
   output q_status_type status
);

   rsp_item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  pop;
   logic [QCNT_WIDTH-1:0] n_push;

   // status and head
   assign status.not_empty = (count_ff != '0);
   assign status.has_room  = (count_ff <= QCNT_WIDTH'(QUEUE_DEPTH - 2));
   assign head             = entry_ff[rd_ptr_ff];
   assign pop              = status.not_empty && pop_ready;
   assign n_push           = QCNT_WIDTH'(push.push_first) + QCNT_WIDTH'(push.push_second);

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(n_push);
      rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(pop);
      count_in  = count_ff + n_push - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, second item lands after the first
   always_ff @(posedge clock) begin
      if (push.push_first) begin
         entry_ff[wr_ptr_ff] <= item_first;
      end
      if (push.push_second) begin
         entry_ff[wr_ptr_ff + QPTR_WIDTH'(1)] <= item_second;
      end
   end

   `CHECK_ALWAYS(a_no_overfill, clock, reset, count_ff <= QCNT_WIDTH'(QUEUE_DEPTH), "queue overfilled")
   `CHECK_ALWAYS(a_push_with_room, clock, reset, !push.push_first || status.has_room, "push without room")
   `CHECK_ALWAYS(a_second_after_first, clock, reset, !push.push_second || push.push_first, "second push alone")
   `CHECK_NEXT(a_pop_drains, clock, reset, pop && !push.push_first, count_ff == $past(count_ff) - QCNT_WIDTH'(1), "pop did not drain")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb import wbps_pkg::*; ();

   localparam int PATTERN_MAX   = 32;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_BYTES  = 1630;
   localparam int MAX_REPORTS   = 60;
   localparam int INDEX_COUNT   = 1 << CSR_INDEX_WIDTH;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED_FIRST = REG_BASE + 1'b1;

   logic clock;
   logic reset;

   wbps_req_if req_chan();
   wbps_rsp_if rsp_chan();
   wbps_csr_if csr_chan();

   wildcard_byte_pattern_scanner u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow copy of the configuration registers
   pattern_bytes_type         cfg_pattern  = '0;
   logic [MASK_WIDTH-1:0]     cfg_mask     = '0;
   logic [LEN_WIDTH-1:0]      cfg_len      = '0;
   logic                      cfg_find_all = 1'b0;
   logic [ADDR_WIDTH-1:0]     cfg_base     = '0;

   // shadow copy of the per-region scan state, element 0 is the newest byte
   logic [PATTERN_MAX-1:0][DATA_WIDTH-1:0] win_bytes  = '0;
   logic [31:0]                            seen_count = '0;
   logic [MATCH_TOTAL_WIDTH-1:0]           hit_count  = '0;
   logic                                   stopped    = 1'b0;

   rsp_item_type due_reports[$];
   int unsigned  fail_count  = 0;
   bit           src_pacing  = 1'b1;
   bit           sink_pacing = 1'b1;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void restart_region();
      win_bytes  = '0;
      seen_count = '0;
      hit_count  = '0;
      stopped    = 1'b0;
   endfunction

   // shift one byte into the window and queue the reports it causes
   function automatic void advance_window(input logic [DATA_WIDTH-1:0] d, input logic eor);
      int unsigned  eff;
      int unsigned  k;
      logic         hit;
      rsp_item_type r;
      eff = (cfg_len > PATTERN_MAX) ? PATTERN_MAX : cfg_len;
      win_bytes = {win_bytes[PATTERN_MAX-2:0], d};
      if (seen_count != '1) seen_count++;
      hit = (eff > 0) && !stopped && (seen_count >= eff);
      for (k = 0; k < eff; k++)
         if (cfg_mask[k] && win_bytes[eff - 1 - k] != cfg_pattern[k]) hit = 1'b0;
      if (hit) begin
         if (hit_count != '1) hit_count++;
         if (!cfg_find_all) stopped = 1'b1;
         r.kind          = KIND_MATCH;
         r.match_address = cfg_base + ADDR_WIDTH'(seen_count - eff);
         r.found_any     = (hit_count != 0);
         r.match_total   = hit_count;
         r.last_of_run   = !eor;
         due_reports.insert(due_reports.size(), r);
      end
      // completion report closes the region
      if (eor) begin
         r.kind          = KIND_COMPLETION;
         r.match_address = '0;
         r.found_any     = (hit_count != 0);
         r.match_total   = hit_count;
         r.last_of_run   = 1'b1;
         due_reports.insert(due_reports.size(), r);
         restart_region();
      end
   endfunction

   task automatic compare_field(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   // compare every accepted result item with the oldest expectation
   always @(posedge clock) begin : check_reports
      rsp_item_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (due_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: report mismatch, expected none, actual kind %0b address %0h",
                        $time, rsp_chan.kind, rsp_chan.match_address);
         end else begin
            want = due_reports.pop_front();
            compare_field("kind", 64'(want.kind), 64'(rsp_chan.kind));
            compare_field("match_address", want.match_address, rsp_chan.match_address);
            compare_field("found_any", 64'(want.found_any), 64'(rsp_chan.found_any));
            compare_field("match_total", 64'(want.match_total), 64'(rsp_chan.match_total));
            compare_field("last_of_run", 64'(want.last_of_run), 64'(rsp_chan.last_of_run));
         end
      end
   end

   // result side, random stall before each item while sink pacing is on
   initial begin : drain_results
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = sink_pacing ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   // watchdog on cycles with no handshake on any channel
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) ||
             (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("status: fail");
      $finish;
   end

   // one byte item, after a random gap while source pacing is on
   task automatic send_byte(input logic [DATA_WIDTH-1:0] d, input logic eor);
      int unsigned gap;
      gap = src_pacing ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= d;
      req_chan.end_of_region <= eor;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      advance_window(d, eor);
   endtask

   // register write; valid stays high when another write follows at once
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] value, input bit more);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      case (idx)
         REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
            cfg_pattern[int'(idx - REG_PATTERN_0) * 8 +: 8] = value;
         REG_CARE_MASK: cfg_mask     = value[MASK_WIDTH-1:0];
         REG_LENGTH:    cfg_len      = value[LEN_WIDTH-1:0];
         REG_FIND_ALL:  cfg_find_all = value[0];
         REG_BASE:      cfg_base     = value;
         default: ;
      endcase
      if (!more) csr_chan.valid <= 1'b0;
   endtask

   // full register set, unused upper bits filled with noise
   task automatic configure(input pattern_bytes_type pat, input logic [MASK_WIDTH-1:0] mask,
                            input logic [LEN_WIDTH-1:0] len, input logic all,
                            input logic [ADDR_WIDTH-1:0] base);
      int unsigned w;
      for (w = 0; w < PATTERN_WORDS; w++)
         write_reg(REG_PATTERN_0 + CSR_INDEX_WIDTH'(w), pat[w*8 +: 8], 1'b1);
      write_reg(REG_CARE_MASK, {$urandom, mask}, 1'b1);
      write_reg(REG_LENGTH, {$urandom, 26'($urandom), len}, 1'b1);
      write_reg(REG_FIND_ALL, {$urandom, 31'($urandom), all}, 1'b1);
      write_reg(REG_BASE, base, 1'b0);
   endtask

   // hold the input until every expected item is back, then let the block settle
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // zero length never matches, even on an all-zero window
   task automatic test_zero_length();
      pattern_bytes_type pat;
      pat = '0;
      configure(pat, '1, '0, 1'b1, '0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      wait_idle();
   endtask

   // address wraps past the top, match on the last byte precedes completion
   task automatic test_wrap_last_byte();
      pattern_bytes_type pat;
      pat    = '1;
      pat[1] = 8'h00;
      configure(pat, '1, LEN_WIDTH'(3), 1'b1, '1 - ADDR_WIDTH'(1));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_idle();
   endtask

   // wildcard in the middle, only the first match reported
   task automatic test_wildcard_first_only();
      pattern_bytes_type pat;
      pat    = '0;
      pat[0] = 8'h12;
      pat[1] = 8'h5A;
      pat[2] = 8'h34;
      configure(pat, 32'hFFFF_FFFD, LEN_WIDTH'(3), 1'b0, ADDR_WIDTH'(32'h1000));
      send_byte(8'h12, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'hCD, 1'b0);
      send_byte(8'h34, 1'b1);
      wait_idle();
   endtask

   // region shorter than the pattern gives only the completion
   task automatic test_short_region();
      write_reg(REG_LENGTH, 64'(4), 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b1);
      wait_idle();
   endtask

   // one-byte pattern on a one-byte region
   task automatic test_single_byte_match();
      write_reg(REG_LENGTH, 64'(1), 1'b0);
      send_byte(8'h12, 1'b1);
      wait_idle();
   endtask

   // pattern rewritten half way through a region, region state kept
   task automatic test_mid_region_config();
      pattern_bytes_type pat;
      pat    = '0;
      pat[0] = 8'hAA;
      pat[1] = 8'hBB;
      configure(pat, '1, LEN_WIDTH'(2), 1'b1, {1'b1, 63'b0});
      send_byte(8'hAA, 1'b0);
      wait_idle();
      write_reg(REG_PATTERN_0, 64'h0000_0000_0000_CCBB, 1'b0);
      send_byte(8'hBB, 1'b0);
      send_byte(8'hCC, 1'b1);
      wait_idle();
   endtask

   // writes to unused indexes leave the configuration alone
   task automatic test_unknown_index();
      int i;
      for (i = int'(REG_UNUSED_FIRST); i < INDEX_COUNT; i++)
         write_reg(CSR_INDEX_WIDTH'(i), {$urandom, $urandom}, i != INDEX_COUNT - 1);
      send_byte(8'hBB, 1'b0);
      send_byte(8'hCC, 1'b1);
      wait_idle();
   endtask

   // random settings, regions seeded with planted copies of the pattern
   task automatic test_random_regions();
      pattern_bytes_type     pat;
      logic [DATA_WIDTH-1:0] region[$];
      logic [MASK_WIDTH-1:0] mask;
      logic [LEN_WIDTH-1:0]  len;
      logic [ADDR_WIDTH-1:0] base;
      int unsigned           total, eff, span, cut, runs, n, i, j;
      bit                    narrow;
      total = 0;
      while (total < RANDOM_BYTES) begin
         narrow = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 19))
            0:       len = '0;
            1:       len = LEN_WIDTH'($urandom_range(PATTERN_MAX + 1, (1 << LEN_WIDTH) - 1));
            2, 3:    len = LEN_WIDTH'($urandom_range(9, PATTERN_MAX));
            4:       len = LEN_WIDTH'(PATTERN_MAX);
            default: len = LEN_WIDTH'($urandom_range(1, 8));
         endcase
         // oversized length at least once
         if (total == 0) len = '1;
         eff = (len > PATTERN_MAX) ? PATTERN_MAX : len;
         for (j = 0; j < PATTERN_MAX; j++)
            pat[j] = narrow ? DATA_WIDTH'($urandom_range(0, 1)) : DATA_WIDTH'($urandom);
         case ($urandom_range(0, 7))
            0:       mask = '0;
            1, 2:    mask = '1;
            3:       mask = $urandom;
            default: mask = $urandom | $urandom;
         endcase
         case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1 - ADDR_WIDTH'($urandom_range(0, 40));
            default: base = {$urandom, $urandom};
         endcase
         configure(pat, mask, len, 1'($urandom_range(0, 1)), base);

         runs = $urandom_range(1, 3);
         for (n = 0; n < runs; n++) begin
            if (eff == 0)
               span = $urandom_range(1, 12);
            else if ($urandom_range(0, 9) == 0)
               span = $urandom_range(1, eff);
            else
               span = $urandom_range(eff, eff + (eff > 8 ? 16 : 30));
            region.delete();
            while (region.size() < span) begin
               if (eff > 0 && $urandom_range(0, 2) == 0) begin
                  // planted copy, wildcard positions take any byte
                  for (j = 0; j < eff; j++)
                     region.insert(region.size(),
                                   cfg_mask[j] ? cfg_pattern[j] : DATA_WIDTH'($urandom));
               end else if (narrow) begin
                  region.insert(region.size(), DATA_WIDTH'($urandom_range(0, 1)));
               end else begin
                  region.insert(region.size(), DATA_WIDTH'($urandom));
               end
            end
            src_pacing  = ($urandom_range(0, 3) != 0);
            sink_pacing = ($urandom_range(0, 3) != 0);
            cut = (span > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, span - 1) : 0;
            for (i = 0; i < span; i++) begin
               // occasional register change inside the region
               if (cut != 0 && i == cut) begin
                  wait_idle();
                  write_reg(CSR_INDEX_WIDTH'($urandom_range(0, REG_BASE)),
                            {$urandom, $urandom}, 1'b0);
               end
               send_byte(region[i], i == span - 1);
            end
            total += span;
         end
         wait_idle();
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= '0;
      req_chan.end_of_region <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= '0;
      csr_chan.data          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_zero_length();
      test_wrap_last_byte();
      test_wildcard_first_only();
      test_short_region();
      test_single_byte_match();
      test_mid_region_config();
      test_unknown_index();
      test_random_regions();

      wait_idle();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
